// ===== design/oht_pkg.sv =====
// Package for the object handle table: field widths, default sizes and codes.
// Depends on nothing; the interfaces and the core import it.
`default_nettype none

package oht_pkg;

	// Default table geometry.
	localparam int SLOTS_DEF     = 1024;
	localparam int SIZE_BITS_DEF = 24;

	// Fixed widths of the channel fields.
	localparam int CMD_W    = 3;
	localparam int HANDLE_W = 10;
	localparam int FIELD_W  = 24;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 34;

	// Command codes; codes above CMD_ACCESS do nothing.
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_RESIZE  = 3'd2,
		CMD_QUERY   = 3'd3,
		CMD_ACCESS  = 3'd4
	} cmd_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_BAD  = 2'd2,
		STAT_OVER = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_FETCH,
		S_STEP2,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== design/oht_req_if.sv =====
// Request channel of the object handle table: valid/ready plus the command word.
// Depends on oht_pkg for the field widths.
`default_nettype none

interface oht_req_if
	import oht_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [HANDLE_W-1:0] handle;
	logic [FIELD_W-1:0]  obj_size;
	logic [FIELD_W-1:0]  offset;
	logic [FIELD_W-1:0]  length;

	modport source (output valid, cmd, handle, obj_size, offset, length, input ready);
	modport sink   (input valid, cmd, handle, obj_size, offset, length, output ready);
endinterface

`default_nettype wire

// ===== design/oht_rsp_if.sv =====
// Response channel of the object handle table: valid/ready plus the result word.
// Depends on oht_pkg for the field widths.
`default_nettype none

interface oht_rsp_if
	import oht_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [FIELD_W-1:0]  size_out;
	logic [FIELD_W-1:0]  length_out;
	logic [TOTAL_W-1:0]  total_used;

	modport source (output valid, status, handle_out, size_out, length_out, total_used,
		input ready);
	modport sink   (input valid, status, handle_out, size_out, length_out, total_used,
		output ready);
endinterface

`default_nettype wire

// ===== design/object_handle_table_core.sv =====
// Object handle table core: slot memory, next-fit allocator, sequencer and one shared adder.
// Depends on oht_pkg, oht_req_if and oht_rsp_if.
//
//   Channel  Dir  Handshake     Word
//   req      in   valid/ready   cmd, handle, obj_size, offset, length
//   rsp      out  valid/ready   status, handle_out, size_out, length_out, total_used
//
// After reset a clearing pass writes every slot once before req.ready rises. Allocate walks
// the slots next-fit, one read per cycle, and checks at most SLOTS - 1 of them. Release and
// query with an in-range handle pass through the fetch state; resize and access also take a
// second adder step, skipped when the handle is rejected, since they use the shared adder
// twice; an unknown command goes straight to finish. A finished word waits in the output
// register; the next word is accepted meanwhile, and its result holds in the finish state until rsp drains.
`default_nettype none

module object_handle_table_core
	import oht_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	oht_req_if.sink    req,
	oht_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int ALU_W = TOTAL_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// Next slot of the walk, skipping the root.
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
		logic [IDX_W-1:0] n;
		n = (s == LAST_IDX) ? IDX_W'(1) : s + 1'b1;
		return n;
	endfunction

	// Sequencer and control registers.
	state_t state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] search_q;
	logic             pend_q;
	logic [TOTAL_W-1:0] total_q;
	logic             out_valid_q;

	// Working registers of the current word.
	logic [CMD_W-1:0]     cmd_q;
	logic [HANDLE_W-1:0]  hnd_q;
	logic [SIZE_BITS-1:0] sz_q;
	logic [FIELD_W-1:0]   off_q;
	logic [FIELD_W-1:0]   len_q;
	logic [IDX_W-1:0]     scan_q;
	logic [IDX_W-1:0]     chk_q;
	logic [IDX_W-1:0]     first_q;
	logic [SIZE_BITS-1:0] old_q;
	logic [SIZE_BITS-1:0] diff_q;
	logic                 neg_q;
	status_t              res_status_q;
	logic [HANDLE_W-1:0]  res_hout_q;
	logic [FIELD_W-1:0]   res_sout_q;
	logic [FIELD_W-1:0]   res_lout_q;

	// Output register.
	status_t             out_status_q;
	logic [HANDLE_W-1:0] out_hout_q;
	logic [FIELD_W-1:0]  out_sout_q;
	logic [FIELD_W-1:0]  out_lout_q;
	logic [TOTAL_W-1:0]  out_total_q;

	// Slot memory: top bit is the used flag, the rest the byte size.
	logic [SIZE_BITS:0] mem_q [SLOTS];
	logic [SIZE_BITS:0] rd_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [SIZE_BITS:0] mem_wdata;

	// Shared adder/subtractor.
	logic [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic             alu_sub;
	logic             alu_neg;

	logic                 in_rdy;
	logic                 accept;
	logic                 req_in_range;
	logic                 req_is_handle_cmd;
	logic [IDX_W-1:0]     hnd_idx;
	logic                 rd_used;
	logic [SIZE_BITS-1:0] rd_size;
	logic                 fetch_ok;
	logic                 grant;
	logic                 full;
	logic                 out_free;

	// Decode of the incoming word and of the slot just read.
	assign accept            = req.valid && in_rdy;
	assign req_in_range      = 32'(req.handle) < SLOTS;
	assign req_is_handle_cmd = req.cmd inside {CMD_RELEASE, CMD_RESIZE, CMD_QUERY, CMD_ACCESS};
	assign hnd_idx           = IDX_W'(hnd_q);
	assign rd_used           = rd_q[SIZE_BITS];
	assign rd_size           = rd_q[SIZE_BITS-1:0];
	assign fetch_ok          = rd_used && !((cmd_q == CMD_RELEASE) && (hnd_q == '0));
	assign grant             = pend_q && !rd_used;
	assign full              = pend_q && rd_used && (next_slot(chk_q) == first_q);
	assign out_free          = !out_valid_q || rsp.ready;

	// Shared adder: a plus or minus b, the top bit flags a negative difference.
	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign alu_neg = alu_res[ALU_W-1];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_ALLOC) begin
						state_d = S_SEARCH;
					end else if (req_is_handle_cmd && req_in_range) begin
						state_d = S_FETCH;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SEARCH: begin
				if (grant || full) begin
					state_d = S_FINISH;
				end
			end
			S_FETCH: begin
				if (fetch_ok && (cmd_q == CMD_RESIZE || cmd_q == CMD_ACCESS)) begin
					state_d = S_STEP2;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_STEP2: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs: ready, memory port controls and adder operands.
	always_comb begin
		in_rdy    = 1'b0;
		rd_addr   = scan_q;
		mem_we    = 1'b0;
		mem_waddr = hnd_idx;
		mem_wdata = '0;
		alu_a     = ALU_W'(total_q);
		alu_b     = ALU_W'(sz_q);
		alu_sub   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {(clr_q == '0), {SIZE_BITS{1'b0}}};
			end
			S_IDLE: begin
				in_rdy  = 1'b1;
				rd_addr = IDX_W'(req.handle);
			end
			S_SEARCH: begin
				mem_we    = grant;
				mem_waddr = chk_q;
				mem_wdata = {1'b1, sz_q};
			end
			S_FETCH: begin
				case (cmd_q)
					CMD_RELEASE: begin
						mem_we  = fetch_ok;
						alu_b   = ALU_W'(rd_size);
						alu_sub = 1'b1;
					end
					CMD_RESIZE: begin
						mem_we    = fetch_ok;
						mem_wdata = {1'b1, sz_q};
					end
					CMD_ACCESS: begin
						alu_a   = ALU_W'(rd_size);
						alu_b   = ALU_W'(off_q);
						alu_sub = 1'b1;
					end
					default: begin
						alu_sub = 1'b0;
					end
				endcase
			end
			S_STEP2: begin
				alu_sub = 1'b1;
				if (cmd_q == CMD_ACCESS) begin
					alu_a = ALU_W'(diff_q);
					alu_b = ALU_W'(len_q);
				end else begin
					alu_b = ALU_W'(old_q);
				end
			end
			default: begin
				in_rdy = 1'b0;
			end
		endcase
	end

	assign req.ready = in_rdy;

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			search_q    <= IDX_W'(1);
			pend_q      <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// Walk bookkeeping and the grant's next-fit start.
			if (state_q == S_IDLE) begin
				pend_q <= 1'b0;
			end else if (state_q == S_SEARCH) begin
				pend_q <= 1'b1;
				if (grant) begin
					search_q <= next_slot(chk_q);
				end
			end
			// Running byte total goes through the shared adder.
			if ((state_q == S_SEARCH && grant) ||
				(state_q == S_FETCH && fetch_ok &&
				 (cmd_q == CMD_RELEASE || cmd_q == CMD_RESIZE)) ||
				(state_q == S_STEP2 && cmd_q == CMD_RESIZE)) begin
				total_q <= TOTAL_W'(alu_res);
			end
			// Output register valid.
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the word in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q        <= req.cmd;
					hnd_q        <= req.handle;
					sz_q         <= SIZE_BITS'(req.obj_size);
					off_q        <= req.offset;
					len_q        <= req.length;
					scan_q       <= search_q;
					first_q      <= search_q;
					res_status_q <= (req_is_handle_cmd && !req_in_range) ? STAT_BAD : STAT_OK;
					res_hout_q   <= '0;
					res_sout_q   <= '0;
					res_lout_q   <= '0;
				end
			end
			S_SEARCH: begin
				if (grant) begin
					res_hout_q <= HANDLE_W'(chk_q);
				end else if (full) begin
					res_status_q <= STAT_FULL;
				end else begin
					chk_q  <= scan_q;
					scan_q <= next_slot(scan_q);
				end
			end
			S_FETCH: begin
				old_q  <= rd_size;
				diff_q <= SIZE_BITS'(alu_res);
				neg_q  <= alu_neg;
				if (!fetch_ok) begin
					res_status_q <= STAT_BAD;
				end else if (cmd_q == CMD_QUERY) begin
					res_sout_q <= FIELD_W'(rd_size);
				end
			end
			S_STEP2: begin
				// Access: offset past the end, then offset plus length past the end.
				if (cmd_q == CMD_ACCESS) begin
					if (neg_q) begin
						res_status_q <= STAT_OVER;
					end else if (alu_neg) begin
						res_status_q <= STAT_OVER;
						res_lout_q   <= FIELD_W'(diff_q);
					end else begin
						res_lout_q <= len_q;
					end
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_hout_q   <= res_hout_q;
			out_sout_q   <= res_sout_q;
			out_lout_q   <= res_lout_q;
			out_total_q  <= total_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.handle_out = out_hout_q;
	assign rsp.size_out   = out_sout_q;
	assign rsp.length_out = out_lout_q;
	assign rsp.total_used = out_total_q;

	// The root slot is never written as free.
	a_root_used: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_waddr == '0) |-> mem_wdata[SIZE_BITS])
		else $error("root slot written as free");

	// The next-fit start never points at the root.
	a_search_nonroot: assert property (@(posedge clk) disable iff (!arst_n)
		search_q != '0)
		else $error("allocation search starts at the root");

	// An allocate writes only a slot that it read as free.
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && mem_we) |-> (pend_q && !rd_used && chk_q != '0))
		else $error("allocate wrote a used slot");

	// A finished word holds while the output register is still occupied.
	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_valid_q && !rsp.ready) |=> (state_q == S_FINISH))
		else $error("result overwrote a waiting word");

	// Only a successful allocate reports a handle.
	a_hout_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_OK) |-> (rsp.handle_out == '0))
		else $error("handle reported with a failing status");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for object_handle_table_core: a queue-fed driver on the request
// channel, a stalling receiver and a monitor that checks every result word against a slot table.
// Depends on oht_pkg, oht_req_if, oht_rsp_if and the core.
module tb_top
	import oht_pkg::*;
	();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = SLOTS_DEF;
	localparam int SIZE_W       = SIZE_BITS_DEF;
	localparam int RESET_CYCLES = 7;
	// Slowest correct run: about 1900 words, each with a next-fit walk over up to SLOTS slots,
	// plus sender gaps and receiver stalls, a clearing pass and one long hold. This is several times that.
	localparam int LIMIT_CYCLES = 8_000_000;
	localparam int DRAIN_CYCLES = SLOTS + 16;
	localparam int REPORT_MAX   = 10;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 600;
	localparam int ITEM_GOAL    = 1850;

	// One request word, one result word, and the bookkeeping of the whole table.
	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [HANDLE_W-1:0] handle;
		logic [FIELD_W-1:0]  obj_size;
		logic [FIELD_W-1:0]  offset;
		logic [FIELD_W-1:0]  length;
	} oht_cmd_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle_out;
		logic [FIELD_W-1:0]  size_out;
		logic [FIELD_W-1:0]  length_out;
		logic [TOTAL_W-1:0]  total_used;
	} oht_res_t;

	typedef struct packed {
		logic [SLOTS-1:0]              used;
		logic [SLOTS-1:0][SIZE_W-1:0]  size;
		logic [HANDLE_W-1:0]           next_try;
		logic [TOTAL_W-1:0]            total;
	} slot_table_t;

	typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} rdy_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	oht_req_if req_ch();
	oht_rsp_if rsp_ch();

	object_handle_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	oht_cmd_t    cmd_backlog[$];
	oht_res_t    due_results[$];
	slot_table_t plan_tbl;
	slot_table_t live_tbl;
	logic        req_fired = 1'b0;
	int          accepted_cnt = 0;
	int          fail_cnt = 0;
	longint      cycle_cnt = 0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	rdy_mode_t   rdy_mode = RDY_ALWAYS;
	int          rdy_left = 0;
	int          rdy_phase = 0;

	function automatic slot_table_t fresh_table();
		slot_table_t t;
		t = '0;
		t.used[0] = 1'b1;
		t.next_try = HANDLE_W'(1);
		return t;
	endfunction

	function automatic logic [HANDLE_W-1:0] after_slot(logic [HANDLE_W-1:0] s);
		return (int'(s) >= SLOTS - 1) ? HANDLE_W'(1) : s + 1'b1;
	endfunction

	// Applies one command to a table and returns the result word it produces.
	function automatic oht_res_t table_step(inout slot_table_t t, input oht_cmd_t c);
		oht_res_t r;
		logic [HANDLE_W-1:0] idx;
		logic [SIZE_W-1:0] osz;
		logic found;
		logic live;
		int n;
		r = '0;
		r.status = STAT_OK;
		live = (int'(c.handle) < SLOTS) && t.used[c.handle];
		osz = t.size[c.handle];
		case (c.cmd)
		CMD_ALLOC: begin
			// Next-fit walk over slots 1..SLOTS-1, starting where the last grant left off.
			idx = (t.next_try == '0) ? HANDLE_W'(1) : t.next_try;
			found = 1'b0;
			for (n = 0; n < SLOTS - 1 && !found; n++) begin
				if (t.used[idx])
					idx = after_slot(idx);
				else
					found = 1'b1;
			end
			if (found) begin
				t.used[idx] = 1'b1;
				t.size[idx] = c.obj_size;
				t.total = t.total + c.obj_size;
				t.next_try = after_slot(idx);
				r.handle_out = idx;
			end else begin
				r.status = STAT_FULL;
			end
		end
		CMD_RELEASE: begin
			if (c.handle == '0 || !live) begin
				r.status = STAT_BAD;
			end else begin
				t.total = t.total - osz;
				t.used[c.handle] = 1'b0;
				t.size[c.handle] = '0;
			end
		end
		CMD_RESIZE: begin
			if (!live) begin
				r.status = STAT_BAD;
			end else begin
				t.total = t.total + c.obj_size - osz;
				t.size[c.handle] = c.obj_size;
			end
		end
		CMD_QUERY: begin
			if (!live)
				r.status = STAT_BAD;
			else
				r.size_out = osz;
		end
		CMD_ACCESS: begin
			// The length is clipped to what is left of the object past the offset.
			if (!live) begin
				r.status = STAT_BAD;
			end else if (c.offset > osz) begin
				r.status = STAT_OVER;
			end else if ({1'b0, c.offset} + {1'b0, c.length} > {1'b0, osz}) begin
				r.status = STAT_OVER;
				r.length_out = osz - c.offset;
			end else begin
				r.length_out = c.length;
			end
		end
		default: ;
		endcase
		r.total_used = t.total;
		return r;
	endfunction

	// Stimulus helpers; the plan table tracks which handles are live at each point.
	task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [HANDLE_W-1:0] h,
			input logic [FIELD_W-1:0] sz, input logic [FIELD_W-1:0] off,
			input logic [FIELD_W-1:0] len);
		oht_cmd_t w;
		w.cmd = c;
		w.handle = h;
		w.obj_size = sz;
		w.offset = off;
		w.length = len;
		void'(table_step(plan_tbl, w));
		cmd_backlog.push_back(w);
	endtask

	function automatic logic [HANDLE_W-1:0] pick_live(bit skip_root);
		logic [HANDLE_W-1:0] h;
		int n;
		h = '0;
		for (n = 0; n < 256; n++) begin
			h = HANDLE_W'($urandom);
			if (plan_tbl.used[h] && !(skip_root && h == '0))
				return h;
		end
		return h;
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle(bit skip_root);
		return ($urandom_range(0, 9) == 0) ? HANDLE_W'($urandom) : pick_live(skip_root);
	endfunction

	function automatic logic [FIELD_W-1:0] rnd_size();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2, 3: return FIELD_W'($urandom_range(0, 255));
		default: return FIELD_W'($urandom);
		endcase
	endfunction

	task automatic queue_access(input logic [HANDLE_W-1:0] h);
		logic [FIELD_W-1:0] osz;
		logic [FIELD_W-1:0] off;
		logic [FIELD_W-1:0] len;
		osz = plan_tbl.size[h];
		case ($urandom_range(0, 3))
		0: begin
			off = FIELD_W'($urandom_range(0, osz));
			len = FIELD_W'($urandom_range(0, osz - off));
		end
		1: begin
			off = FIELD_W'($urandom_range(0, osz));
			len = FIELD_W'($urandom);
		end
		2: begin
			off = FIELD_W'($urandom);
			len = FIELD_W'($urandom);
		end
		default: begin
			off = osz;
			len = FIELD_W'($urandom_range(0, 1));
		end
		endcase
		queue_cmd(CMD_ACCESS, h, FIELD_W'($urandom), off, len);
	endtask

	task automatic random_op(input int alloc_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < alloc_w) begin
			queue_cmd(CMD_ALLOC, HANDLE_W'($urandom), rnd_size(), FIELD_W'($urandom),
				FIELD_W'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 30)
				queue_cmd(CMD_RELEASE, pick_handle(1'b1), FIELD_W'($urandom),
					FIELD_W'($urandom), FIELD_W'($urandom));
			else if (r < 50)
				queue_cmd(CMD_RESIZE, pick_handle(1'b0), rnd_size(), FIELD_W'($urandom),
					FIELD_W'($urandom));
			else if (r < 70)
				queue_cmd(CMD_QUERY, pick_handle(1'b0), FIELD_W'($urandom),
					FIELD_W'($urandom), FIELD_W'($urandom));
			else if (r < 95)
				queue_access(pick_handle(1'b0));
			else
				queue_cmd(CMD_W'($urandom_range(int'(CMD_ACCESS) + 1, (1 << CMD_W) - 1)),
					HANDLE_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
					FIELD_W'($urandom));
		end
	endtask

	// Request driver: presents the next pending word at the falling edge.
	always @(negedge clk) begin
		oht_cmd_t nxt;
		if (arst_n && (!req_ch.valid || req_fired)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				nxt = cmd_backlog.pop_front();
				req_ch.cmd <= nxt.cmd;
				req_ch.handle <= nxt.handle;
				req_ch.obj_size <= nxt.obj_size;
				req_ch.offset <= nxt.offset;
				req_ch.length <= nxt.length;
				req_ch.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: a changing ready pattern, plus one long hold to back the block up.
	always @(negedge clk) begin
		if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rdy_left == 0) begin
				rdy_mode = rdy_mode_t'($urandom_range(0, 3));
				rdy_left = $urandom_range(32, 256);
			end else begin
				rdy_left--;
			end
			rdy_phase = (rdy_phase + 1) % 5;
			case (rdy_mode)
			RDY_ALWAYS: rsp_ch.ready <= 1'b1;
			RDY_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			RDY_RARELY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			default: rsp_ch.ready <= (rdy_phase < 2);
			endcase
		end
	end

	// Monitor: predicts each accepted word and checks each delivered result word.
	always @(posedge clk) begin
		oht_cmd_t taken;
		oht_res_t want;
		oht_res_t seen;
		if (arst_n) begin
			req_fired <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.status = status_t'(rsp_ch.status);
				seen.handle_out = rsp_ch.handle_out;
				seen.size_out = rsp_ch.size_out;
				seen.length_out = rsp_ch.length_out;
				seen.total_used = rsp_ch.total_used;
				if (due_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("unexpected result: status=%0d handle=%0d size=%h len=%h total=%h",
							seen.status, seen.handle_out, seen.size_out, seen.length_out,
							seen.total_used);
				end else begin
					want = due_results.pop_front();
					if (seen !== want) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_MAX) begin
							$display("mismatch exp/act: status %0d/%0d handle %0d/%0d",
								want.status, seen.status, want.handle_out, seen.handle_out);
							$display("  size %h/%h len %h/%h total %h/%h",
								want.size_out, seen.size_out, want.length_out,
								seen.length_out, want.total_used, seen.total_used);
						end
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				taken.cmd = req_ch.cmd;
				taken.handle = req_ch.handle;
				taken.obj_size = req_ch.obj_size;
				taken.offset = req_ch.offset;
				taken.length = req_ch.length;
				due_results.push_back(table_step(live_tbl, taken));
				accepted_cnt++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("** object_handle_table_core: FAILED **");
			$finish;
		end
	end

	initial begin
		int c;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.handle = '0;
		req_ch.obj_size = '0;
		req_ch.offset = '0;
		req_ch.length = '0;
		rsp_ch.ready = 1'b0;
		plan_tbl = fresh_table();
		live_tbl = fresh_table();

		// Directed words: root handling, bad handles, clipping cases, unknown codes.
		queue_cmd(CMD_QUERY, '0, '0, '0, '0);
		queue_cmd(CMD_ACCESS, '0, '0, '0, '0);
		queue_cmd(CMD_ALLOC, '0, '1, '0, '0);
		queue_cmd(CMD_ALLOC, '1, '0, '1, '1);
		queue_cmd(CMD_QUERY, HANDLE_W'(1), '0, '0, '0);
		queue_cmd(CMD_QUERY, HANDLE_W'(2), '0, '0, '0);
		queue_cmd(CMD_RESIZE, '0, '1, '0, '0);
		queue_cmd(CMD_RELEASE, '0, '0, '0, '0);
		queue_cmd(CMD_RELEASE, '1, '0, '0, '0);
		queue_cmd(CMD_QUERY, '1, '0, '0, '0);
		queue_cmd(CMD_RESIZE, '1, 24'h123456, '0, '0);
		queue_cmd(CMD_ACCESS, '1, '0, '0, '0);
		queue_cmd(CMD_ACCESS, HANDLE_W'(1), '0, '1, '1);
		queue_cmd(CMD_ACCESS, HANDLE_W'(2), '0, FIELD_W'(1), '0);
		queue_cmd(CMD_ACCESS, HANDLE_W'(1), '0, 24'h000010, '1);
		queue_cmd(CMD_ACCESS, HANDLE_W'(1), '0, '0, '1);
		queue_cmd(CMD_ACCESS, HANDLE_W'(1), '0, 24'h0ABCDE, 24'h000100);
		for (c = int'(CMD_ACCESS) + 1; c < (1 << CMD_W); c++)
			queue_cmd(CMD_W'(c), '1, '1, '1, '1);
		queue_cmd(CMD_RELEASE, HANDLE_W'(1), '0, '0, '0);
		queue_cmd(CMD_RELEASE, HANDLE_W'(1), '0, '0, '0);
		queue_cmd(CMD_RESIZE, HANDLE_W'(2), 24'h800000, '0, '0);
		queue_cmd(CMD_ALLOC, '0, FIELD_W'(1), '0, '0);
		queue_cmd(CMD_RESIZE, HANDLE_W'(2), '0, '0, '0);
		queue_cmd(CMD_QUERY, HANDLE_W'(2), '0, '0, '0);

		// Mixed traffic while the table slowly fills.
		repeat (500)
			random_op(50);

		// Fill the table with large objects, then hit store full and churn a full table.
		while ($countones(plan_tbl.used) < SLOTS) begin
			if ($urandom_range(0, 9) == 0)
				queue_access(pick_live(1'b0));
			else
				queue_cmd(CMD_ALLOC, HANDLE_W'($urandom),
					FIELD_W'($urandom_range(24'h800000, 24'hFFFFFF)),
					FIELD_W'($urandom), FIELD_W'($urandom));
		end
		repeat (3)
			queue_cmd(CMD_ALLOC, HANDLE_W'($urandom), rnd_size(), FIELD_W'($urandom),
				FIELD_W'($urandom));
		repeat (40) begin
			queue_cmd(CMD_RELEASE, pick_live(1'b1), FIELD_W'($urandom), FIELD_W'($urandom),
				FIELD_W'($urandom));
			random_op(0);
			queue_cmd(CMD_ALLOC, HANDLE_W'($urandom), rnd_size(), '0, '0);
			queue_cmd(CMD_ALLOC, HANDLE_W'($urandom), rnd_size(), '0, '0);
		end

		// Drain traffic: releases outweigh grants.
		while (cmd_backlog.size() < ITEM_GOAL)
			random_op(20);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || req_ch.valid || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0) begin
			$display("** object_handle_table_core: PASSED **");
		end else begin
			$display("** object_handle_table_core: FAILED **");
		end
		$finish;
	end

endmodule
